FILE: src/iida_pkg.sv
// Shared types, codes and sizing constants for the indexed insert/delete array.
package iida_pkg;

  // Fixed field widths of the request and response words.
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 3;

  // Default sizing of the array.
  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  // Width of positions and counts inside the command word; wide enough for
  // the largest supported capacity plus one.
  localparam int CNT_W = 11;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ      = 3'd0,
    ACT_OVERWRITE = 3'd1,
    ACT_INSERT    = 3'd2,
    ACT_DELETE    = 3'd3,
    ACT_RESIZE    = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_CAPACITY  = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  // Operations the cell row can apply.
  typedef enum logic [2:0] {
    DP_NONE   = 3'd0,
    DP_WRITE  = 3'd1,
    DP_INSERT = 3'd2,
    DP_DELETE = 3'd3,
    DP_FILL   = 3'd4,
    DP_APPEND = 3'd5
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             load;
    logic             rd_en;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] fill_lo;
  } dp_cmd_t;

endpackage

FILE: src/iida_if.sv
// Request and response channel interfaces of the indexed insert/delete array.
interface iida_req_if #(
  parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [iida_pkg::ACTION_W-1:0] action;
  logic [iida_pkg::POS_W-1:0]    position;
  logic signed [WORD_BITS-1:0]   data_value;

  modport source (output valid, output action, output position, output data_value,
                  input ready);
  modport sink   (input valid, input action, input position, input data_value,
                  output ready);
endinterface

interface iida_rsp_if #(
  parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [WORD_BITS-1:0]   read_data;
  logic [iida_pkg::LEN_W-1:0]    length;
  logic [iida_pkg::STATUS_W-1:0] status;

  modport source (output valid, output read_data, output length, output status,
                  input ready);
  modport sink   (input valid, input read_data, input length, input status,
                  output ready);
endinterface

FILE: src/iida_ctrl.sv
// Controller: handshake state machine, length register and action decode.
module iida_ctrl #(
  parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iida_pkg::ACTION_W-1:0] action,
  input  logic [iida_pkg::POS_W-1:0]    position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iida_pkg::LEN_W-1:0]    length,
  output logic [iida_pkg::STATUS_W-1:0] status,
  output iida_pkg::dp_cmd_t             cmd
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [iida_pkg::CNT_W-1:0] CAP_X = iida_pkg::CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_FULL  = 2'b10
  } state_t;

  state_t                        state, state_next;
  logic [CW-1:0]                 valid_count, valid_count_next;
  logic [iida_pkg::CNT_W-1:0]    cnt_x, pos_x, new_cnt;
  iida_pkg::status_t             stat_next;
  logic                          accept;

  assign in_ready = (state == S_EMPTY) || out_ready;
  assign accept   = in_valid && in_ready;
  assign out_valid = (state == S_FULL);
  assign cnt_x    = iida_pkg::CNT_W'(valid_count);
  assign pos_x    = iida_pkg::CNT_W'(position);

  always_comb begin
    cmd         = '0;
    cmd.op      = iida_pkg::DP_NONE;
    cmd.load    = accept;
    cmd.pos     = pos_x;
    cmd.fill_lo = cnt_x;
    stat_next   = iida_pkg::STAT_OK;
    new_cnt     = cnt_x;
    unique case (action)
      iida_pkg::ACT_READ: begin
        if (pos_x < cnt_x) cmd.rd_en = 1'b1;
        else stat_next = iida_pkg::STAT_RANGE;
      end
      iida_pkg::ACT_OVERWRITE: begin
        if (pos_x < cnt_x) cmd.op = iida_pkg::DP_WRITE;
        else stat_next = iida_pkg::STAT_RANGE;
      end
      iida_pkg::ACT_INSERT: begin
        if (pos_x < cnt_x) begin
          if (cnt_x + 1'b1 > CAP_X) begin
            stat_next = iida_pkg::STAT_CAPACITY;
          end else begin
            cmd.op  = iida_pkg::DP_INSERT;
            new_cnt = cnt_x + 1'b1;
          end
        end else if (pos_x + 1'b1 > CAP_X) begin
          stat_next = iida_pkg::STAT_CAPACITY;
        end else begin
          cmd.op  = iida_pkg::DP_APPEND;
          new_cnt = pos_x + 1'b1;
        end
      end
      iida_pkg::ACT_DELETE: begin
        if (cnt_x == '0) begin
          stat_next = iida_pkg::STAT_EMPTY;
        end else begin
          cmd.op  = iida_pkg::DP_DELETE;
          new_cnt = cnt_x - 1'b1;
        end
      end
      iida_pkg::ACT_RESIZE: begin
        if (pos_x > CAP_X) begin
          stat_next = iida_pkg::STAT_CAPACITY;
        end else begin
          cmd.op  = iida_pkg::DP_FILL;
          new_cnt = pos_x;
        end
      end
      iida_pkg::ACT_CLEAR: new_cnt = '0;
      default: ;
    endcase
    if (!accept) begin
      cmd.op    = iida_pkg::DP_NONE;
      cmd.rd_en = 1'b0;
    end
    valid_count_next = accept ? CW'(new_cnt) : valid_count;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_EMPTY: if (accept) state_next = S_FULL;
      S_FULL:  if (out_ready && !accept) state_next = S_EMPTY;
      default: state_next = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_EMPTY;
      valid_count <= '0;
    end else begin
      state       <= state_next;
      valid_count <= valid_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      length <= iida_pkg::LEN_W'(new_cnt);
      status <= stat_next;
    end
  end

endmodule

FILE: src/iida_dp.sv
// Datapath: a row of word cells that write, shift up, shift down or zero-fill.
module iida_dp #(
  parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF,
  parameter int CAPACITY  = iida_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  iida_pkg::dp_cmd_t           cmd,
  input  logic signed [WORD_BITS-1:0] data_value,
  output logic signed [WORD_BITS-1:0] read_data
);

  logic signed [WORD_BITS-1:0] cells      [CAPACITY];
  logic signed [WORD_BITS-1:0] cells_next [CAPACITY];
  logic signed [WORD_BITS-1:0] rd_sel;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
    localparam logic [iida_pkg::CNT_W-1:0] IDX = iida_pkg::CNT_W'(i);

    always_comb begin
      cells_next[i] = cells[i];
      unique case (cmd.op)
        iida_pkg::DP_WRITE: begin
          if (IDX == cmd.pos) cells_next[i] = data_value;
        end
        iida_pkg::DP_INSERT: begin
          if (IDX == cmd.pos) cells_next[i] = data_value;
          else if (IDX > cmd.pos) cells_next[i] = cells[PREV];
        end
        // The last cell has no upper neighbor and keeps its word.
        iida_pkg::DP_DELETE: begin
          if (IDX >= cmd.pos) cells_next[i] = cells[NEXT];
        end
        iida_pkg::DP_FILL: begin
          if (IDX >= cmd.fill_lo && IDX < cmd.pos) cells_next[i] = '0;
        end
        iida_pkg::DP_APPEND: begin
          if (IDX == cmd.pos) cells_next[i] = data_value;
          else if (IDX >= cmd.fill_lo && IDX < cmd.pos) cells_next[i] = '0;
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      cells[i] <= cells_next[i];
    end
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.pos == iida_pkg::CNT_W'(i)) rd_sel = cells[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data <= cmd.rd_en ? rd_sel : '0;
    end
  end

endmodule

FILE: src/indexed_insert_delete_array.sv
// Indexed insert/delete array: top level joining the controller and the cell row.
// The response word for a request is registered and appears in the cycle after it is accepted.
// Throughput: one request word per cycle unless the full output stage stalls;
// each action, shifts included, is one cell update as cells load fixed neighbors.
// Reset (rst, synchronous, active high) empties the array and the output stage;
// the cell contents are not cleared and are never visible before being written.
module indexed_insert_delete_array #(
  parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF,
  parameter int CAPACITY  = iida_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  iida_req_if.sink   req,
  iida_rsp_if.source rsp
);

  // The controller owns the length register and decides, for each accepted
  // request word, which single operation the cell row performs. It also holds
  // the response stage, which accepts a new word while the old one is taken.
  iida_pkg::dp_cmd_t cmd;

  iida_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .action    (req.action),
    .position  (req.position),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .length    (rsp.length),
    .status    (rsp.status),
    .cmd       (cmd)
  );

  // The cell row applies the write, the shift up, the shift down or the
  // zero-fill, and registers the read word (zero unless a read inside the
  // current length was requested).
  iida_dp #(
    .WORD_BITS (WORD_BITS),
    .CAPACITY  (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .data_value (req.data_value),
    .read_data  (rsp.read_data)
  );

endmodule

FILE: src/iida_checker.sv
// Port-level assertions for the indexed insert/delete array, bound to the top level.
module iida_checker #(
  parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF,
  parameter int CAPACITY  = iida_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic signed [WORD_BITS-1:0]   read_data,
  input logic [iida_pkg::LEN_W-1:0]    length,
  input logic [iida_pkg::STATUS_W-1:0] status
);

  // A pending response holds its word until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(length)
      && $stable(status))
    else $error("response word changed while stalled");

  // Every error response carries a zero read word.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != iida_pkg::STAT_OK |-> read_data == '0)
    else $error("error response with nonzero read data");

  // A delete from an empty array leaves it empty.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == iida_pkg::STAT_EMPTY |-> length == '0)
    else $error("empty status with nonzero length");

  // The length never exceeds the capacity.
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(length) <= 32'(CAPACITY))
    else $error("length exceeds capacity");

  // Reset drops any pending response.
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind indexed_insert_delete_array iida_checker #(
  .WORD_BITS (WORD_BITS),
  .CAPACITY  (CAPACITY)
) u_iida_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_data (rsp.read_data),
  .length    (rsp.length),
  .status    (rsp.status)
);

FILE: tb/indexed_insert_delete_array_tb.sv
// Self-checking testbench for the indexed insert/delete array.
`timescale 1ns / 100ps

module indexed_insert_delete_array_tb;

  localparam int WORD_BITS = iida_pkg::WORD_BITS_DEF;
  localparam int CAP       = iida_pkg::CAPACITY_DEF;

  // Action codes the block does not define; it must leave the array alone.
  localparam logic [iida_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [iida_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  // Timing of the run. The block answers in the cycle after it takes a word, so
  // a short drain after the last response is enough to catch stray words.
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 10;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_WORDS   = 200;
  localparam int BURST_WORDS   = 60;
  localparam int PRINT_LIMIT   = 50;

  // One response word: the fields the block returns for each request word.
  typedef struct packed {
    logic signed [WORD_BITS-1:0] read_data;
    logic [iida_pkg::LEN_W-1:0]  length;
    iida_pkg::status_t           status;
  } reply_t;

  // One row of the directed script. Rows with known set carry a response
  // typed in by hand; the others are checked against the shadow array.
  typedef struct packed {
    logic [iida_pkg::ACTION_W-1:0] act;
    logic [iida_pkg::POS_W-1:0]    pos;
    logic [WORD_BITS-1:0]          dat;
    bit                            known;
    reply_t                        want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iida_req_if #(.WORD_BITS(WORD_BITS)) req_ch ();
  iida_rsp_if #(.WORD_BITS(WORD_BITS)) rsp_ch ();

  indexed_insert_delete_array #(
    .WORD_BITS(WORD_BITS),
    .CAPACITY (CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow copy of the array: the words and the current length.
  logic signed [WORD_BITS-1:0] shadow_words [CAP];
  int                          shadow_len = 0;

  // Responses the block still owes, oldest first.
  reply_t reply_q [$];

  // Side band that travels with each request word: a hand-typed response.
  bit     row_known = 1'b0;
  reply_t row_want  = '0;

  int words_in     = 0;
  int words_out    = 0;
  int error_count  = 0;
  int quiet_cycles = 0;

  // Pacing knobs set by the stimulus process, read by both sides.
  int sender_idle_pct = 0;
  int rsp_stall_pct   = 0;
  int holds_asked     = 0;
  int holds_served    = 0;

  // Directed script: empty-array errors first, then the word extremes, the
  // zero-filled gap of an insert past the end, deletes inside and past the
  // end, a full array refusing inserts, the undefined codes and a clear.
  script_row_t script [25] = '{
    '{iida_pkg::ACT_READ,      5'd0,  32'h0000_0000, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_RANGE}},
    '{iida_pkg::ACT_DELETE,    5'd0,  32'h0000_0000, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_EMPTY}},
    '{iida_pkg::ACT_OVERWRITE, 5'd3,  32'h1111_1111, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_RANGE}},
    '{iida_pkg::ACT_RESIZE,    5'd17, 32'h0000_0000, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_CAPACITY}},
    '{iida_pkg::ACT_INSERT,    5'd16, 32'h2222_2222, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_CAPACITY}},
    '{iida_pkg::ACT_INSERT,    5'd31, 32'h3333_3333, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_CAPACITY}},
    '{iida_pkg::ACT_INSERT,    5'd0,  32'h7FFF_FFFF, 1'b1,
      '{32'h0,         5'd1,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_INSERT,    5'd0,  32'h8000_0000, 1'b1,
      '{32'h0,         5'd2,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_READ,      5'd0,  32'h0000_0000, 1'b1,
      '{32'h8000_0000, 5'd2,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_READ,      5'd1,  32'h0000_0000, 1'b1,
      '{32'h7FFF_FFFF, 5'd2,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_INSERT,    5'd5,  32'hFFFF_FFFF, 1'b1,
      '{32'h0,         5'd6,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_READ,      5'd3,  32'hFFFF_FFFF, 1'b1,
      '{32'h0,         5'd6,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_OVERWRITE, 5'd2,  32'h1234_5678, 1'b1,
      '{32'h0,         5'd6,  iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_DELETE,    5'd0,  32'h0000_0000, 1'b0, '0},
    '{iida_pkg::ACT_READ,      5'd1,  32'h0000_0000, 1'b0, '0},
    '{iida_pkg::ACT_DELETE,    5'd31, 32'h0000_0000, 1'b0, '0},
    '{iida_pkg::ACT_READ,      5'd31, 32'h0000_0000, 1'b1,
      '{32'h0,         5'd4,  iida_pkg::STAT_RANGE}},
    '{iida_pkg::ACT_RESIZE,    5'd16, 32'h0000_0000, 1'b1,
      '{32'h0,         5'd16, iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_INSERT,    5'd3,  32'h4444_4444, 1'b1,
      '{32'h0,         5'd16, iida_pkg::STAT_CAPACITY}},
    '{iida_pkg::ACT_INSERT,    5'd15, 32'h5555_5555, 1'b1,
      '{32'h0,         5'd16, iida_pkg::STAT_CAPACITY}},
    '{iida_pkg::ACT_READ,      5'd15, 32'h0000_0000, 1'b0, '0},
    '{iida_pkg::ACT_OVERWRITE, 5'd15, 32'h5A5A_A5A5, 1'b1,
      '{32'h0,         5'd16, iida_pkg::STAT_OK}},
    '{ACT_SPARE_6,             5'd1,  32'h6666_6666, 1'b1,
      '{32'h0,         5'd16, iida_pkg::STAT_OK}},
    '{ACT_SPARE_7,             5'd2,  32'h7777_7777, 1'b1,
      '{32'h0,         5'd16, iida_pkg::STAT_OK}},
    '{iida_pkg::ACT_CLEAR,     5'd9,  32'h0000_0000, 1'b1,
      '{32'h0,         5'd0,  iida_pkg::STAT_OK}}
  };

  // Applies one action to the shadow array and returns the response the
  // block has to give for it. Only slots below the length are ever read,
  // and each of them has been written or zero-filled on the way in.
  function automatic reply_t shadow_action(input logic [iida_pkg::ACTION_W-1:0] act,
                                           input logic [iida_pkg::POS_W-1:0] pos,
                                           input logic signed [WORD_BITS-1:0] dat);
    reply_t r;
    int     p;
    int     i;
    p           = pos;
    r.read_data = '0;
    r.status    = iida_pkg::STAT_OK;
    case (act)
      iida_pkg::ACT_READ: begin
        if (p < shadow_len) r.read_data = shadow_words[p];
        else r.status = iida_pkg::STAT_RANGE;
      end
      iida_pkg::ACT_OVERWRITE: begin
        if (p < shadow_len) shadow_words[p] = dat;
        else r.status = iida_pkg::STAT_RANGE;
      end
      iida_pkg::ACT_INSERT: begin
        if (p < shadow_len) begin
          // Inside the array: everything from the position up moves by one.
          if (shadow_len + 1 > CAP) begin
            r.status = iida_pkg::STAT_CAPACITY;
          end else begin
            for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i - 1];
            shadow_words[p] = dat;
            shadow_len++;
          end
        end else if (p + 1 > CAP) begin
          r.status = iida_pkg::STAT_CAPACITY;
        end else begin
          // At or past the end: the gap up to the position reads back as zero.
          for (i = shadow_len; i < p; i++) shadow_words[i] = '0;
          shadow_words[p] = dat;
          shadow_len = p + 1;
        end
      end
      iida_pkg::ACT_DELETE: begin
        // A position past the end shifts nothing and just drops the last word.
        if (shadow_len == 0) begin
          r.status = iida_pkg::STAT_EMPTY;
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_len--;
        end
      end
      iida_pkg::ACT_RESIZE: begin
        if (p > CAP) begin
          r.status = iida_pkg::STAT_CAPACITY;
        end else begin
          for (i = shadow_len; i < p; i++) shadow_words[i] = '0;
          shadow_len = p;
        end
      end
      iida_pkg::ACT_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.length = shadow_len[iida_pkg::LEN_W-1:0];
    return r;
  endfunction

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch: %s at response word %0d: got %h, want %h",
               what, words_out, got, want);
  endtask

  // Request side monitor and response checker. Everything here samples the
  // values from just before the rising edge, so the order in which processes
  // wake up at the edge does not matter. The watchdog ends the run if no word
  // moves on either channel for too long.
  always @(posedge clk) begin : tracker
    reply_t fresh;
    reply_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        fresh = shadow_action(req_ch.action, req_ch.position, req_ch.data_value);
        if (row_known) fresh = row_want;
        reply_q.push_back(fresh);
        words_in++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected response word", rsp_ch.read_data, '0);
        end else begin
          want = reply_q.pop_front();
          if (rsp_ch.read_data !== want.read_data)
            report_mismatch("read_data", rsp_ch.read_data, want.read_data);
          if (rsp_ch.length !== want.length)
            report_mismatch("length", 32'(rsp_ch.length), 32'(want.length));
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        end
        words_out++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Response side: ready is redrawn every cycle according to the stall rate.
  // When the stimulus asks for a hold, ready stays low for a long stretch
  // counted here, so the output stage fills and the block pushes back on its
  // request channel.
  initial begin : response_sink
    int held;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        rsp_ch.ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        holds_served++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Offers one request word, after a random number of idle cycles, and
  // returns at the edge where the block takes it. Valid is left high so a
  // following word goes out back to back.
  task automatic send_word(input logic [iida_pkg::ACTION_W-1:0] act,
                           input logic [iida_pkg::POS_W-1:0] pos,
                           input logic [WORD_BITS-1:0] dat, input bit known,
                           input reply_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.position   <= pos;
    req_ch.data_value <= dat;
    row_known         <= known;
    row_want          <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Random request word. Most positions land inside the array or right at
  // its end, where inserts and deletes actually shift words; the rest spread
  // over the capacity and the whole position field to hit the error paths.
  task automatic send_random_word();
    logic [iida_pkg::ACTION_W-1:0] act;
    logic [iida_pkg::POS_W-1:0]    pos;
    logic [WORD_BITS-1:0]          dat;
    int                            pick;
    pick = $urandom_range(99);
    if (pick < 26)      act = iida_pkg::ACT_READ;
    else if (pick < 42) act = iida_pkg::ACT_OVERWRITE;
    else if (pick < 64) act = iida_pkg::ACT_INSERT;
    else if (pick < 84) act = iida_pkg::ACT_DELETE;
    else if (pick < 93) act = iida_pkg::ACT_RESIZE;
    else if (pick < 96) act = iida_pkg::ACT_CLEAR;
    else if (pick < 98) act = ACT_SPARE_6;
    else                act = ACT_SPARE_7;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if (act == iida_pkg::ACT_RESIZE) pos = iida_pkg::POS_W'($urandom_range(CAP));
      else pos = iida_pkg::POS_W'($urandom_range(shadow_len));
    end else if (pick < 90) begin
      pos = iida_pkg::POS_W'($urandom_range(CAP));
    end else begin
      pos = iida_pkg::POS_W'($urandom_range(31));
    end
    case ($urandom_range(9))
      0: dat = 32'h7FFF_FFFF;
      1: dat = 32'h8000_0000;
      2: dat = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: dat = $urandom;
    endcase
    send_word(act, pos, dat, 1'b0, '0);
  endtask

  // Drops valid and waits until every word sent has been answered. The first
  // edge lets the monitor count the word taken at the edge the sender saw.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (words_in == words_out);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int k;
    int phase;
    req_ch.valid      = 1'b0;
    req_ch.action     = iida_pkg::ACT_READ;
    req_ch.position   = '0;
    req_ch.data_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script with both sides running flat out.
    for (k = 0; k < 25; k++)
      send_word(script[k].act, script[k].pos, script[k].dat, script[k].known,
                script[k].want);
    settle();

    // Random words under four pacing patterns: none, a slow sender, a slow
    // receiver and a mild mix of both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; rsp_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rsp_stall_pct = 73; end
        default: begin sender_idle_pct = 25; rsp_stall_pct = 25; end
      endcase
      for (k = 0; k < PHASE_WORDS; k++) send_random_word();
      settle();
    end

    // Back pressure: the receiver holds off for a long stretch while words
    // keep coming, so the block has to stall its request channel.
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    holds_asked++;
    for (k = 0; k < BURST_WORDS; k++) send_random_word();
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (reply_q.size() != 0)
      report_mismatch("response words never delivered", 32'(reply_q.size()), '0);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/iida_pkg.sv
src/iida_if.sv
src/iida_ctrl.sv
src/iida_dp.sv
src/indexed_insert_delete_array.sv
src/iida_checker.sv
tb/indexed_insert_delete_array_tb.sv
